/* hdl/b64e_pkg.sv */
// ---------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the symbol map of the stream encoder.
// ---------------------------------------------------------------------------
package b64e_pkg;

  // Position of the next byte within its three-byte group.
  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  // Character queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // The queue takes a new byte only when at least two free slots remain.
  localparam logic [Q_CW-1:0] Q_ACCEPT_MAX = Q_CW'(Q_DEPTH - 2);

  // Symbol map boundaries and special characters.
  localparam logic [5:0] SYM_LOWER = 6'd26;
  localparam logic [5:0] SYM_DIGIT = 6'd52;
  localparam logic [5:0] SYM_PLUS  = 6'd62;
  localparam logic [6:0] CHR_UPPER_A = 7'h41;
  localparam logic [6:0] CHR_LOWER_A = 7'h61;
  localparam logic [6:0] CHR_ZERO    = 7'h30;
  localparam logic [6:0] CHR_PLUS    = 7'h2b;
  localparam logic [6:0] CHR_CARET   = 7'h5e;

  // One character as it waits for the output.
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } q_entry_t;

  // Characters produced for one accepted byte.
  typedef struct packed {
    q_entry_t first;
    q_entry_t second;
    logic     two;
  } enc_res_t;

  // Maps a 6-bit symbol onto its ASCII character.
  function automatic logic [6:0] sym_to_ascii(input logic [5:0] sym);
    logic [6:0] s;
    logic [6:0] c;
    s = {1'b0, sym};
    if (sym < SYM_LOWER) begin
      c = CHR_UPPER_A + s;
    end else if (sym < SYM_DIGIT) begin
      c = CHR_LOWER_A + s - {1'b0, SYM_LOWER};
    end else if (sym < SYM_PLUS) begin
      c = CHR_ZERO + s - {1'b0, SYM_DIGIT};
    end else if (sym == SYM_PLUS) begin
      c = CHR_PLUS;
    end else begin
      c = CHR_CARET;
    end
    return c;
  endfunction

endpackage

/* hdl/b64e_encoder.sv */
// ---------------------------------------------------------------------------
// b64e_encoder
// Group phase and carry state, and the split of one byte into symbols.
// ---------------------------------------------------------------------------
module b64e_encoder
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output enc_res_t   res
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic [5:0] sym0, sym1;

  // State advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      carry_r <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  // Next phase and leftover bits; end of message closes the group.
  always_comb begin
    phase_nxt = PH_0;
    carry_nxt = 4'd0;
    if (!end_of_message) begin
      unique case (phase_r)
        PH_1: begin
          phase_nxt = PH_2;
          carry_nxt = data_byte[3:0];
        end
        PH_2: begin
          phase_nxt = PH_0;
          carry_nxt = 4'd0;
        end
        default: begin
          phase_nxt = PH_1;
          carry_nxt = {2'b00, data_byte[1:0]};
        end
      endcase
    end
  end

  // Symbols and flags for this byte.
  always_comb begin
    res.first.last = 1'b0;
    unique case (phase_r)
      PH_1: begin
        sym0            = {carry_r[1:0], data_byte[7:4]};
        sym1            = {data_byte[3:0], 2'b00};
        res.two         = end_of_message;
        res.second.last = 1'b1;
      end
      PH_2: begin
        sym0            = {carry_r, data_byte[7:6]};
        sym1            = data_byte[5:0];
        res.two         = 1'b1;
        res.second.last = end_of_message;
      end
      default: begin
        sym0            = data_byte[7:2];
        sym1            = {data_byte[1:0], 4'b0000};
        res.two         = end_of_message;
        res.second.last = 1'b1;
      end
    endcase
    res.first.ch  = sym_to_ascii(sym0);
    res.second.ch = sym_to_ascii(sym1);
  end

endmodule

/* hdl/b64e_char_queue.sv */
// ---------------------------------------------------------------------------
// b64e_char_queue
// Small character queue that takes one or two characters and gives one.
// ---------------------------------------------------------------------------
module b64e_char_queue
  import b64e_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  enc_res_t wr,
  input  logic     pop,
  output logic     room,
  output logic     not_empty,
  output q_entry_t head
);

  q_entry_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] head_r, tail_r, tail_p1;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic [Q_CW-1:0] n_push;

  assign tail_p1   = tail_r + Q_AW'(1);
  assign n_push    = push ? (wr.two ? Q_CW'(2) : Q_CW'(1)) : Q_CW'(0);
  assign count_nxt = count_r + n_push - (pop ? Q_CW'(1) : Q_CW'(0));
  assign room      = (count_r <= Q_ACCEPT_MAX);
  assign not_empty = (count_r != Q_CW'(0));
  assign head      = mem_r[head_r];

  // Character storage: one or two writes at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= wr.first;
      if (wr.two) begin
        mem_r[tail_p1] <= wr.second;
      end
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        tail_r <= tail_r + n_push[Q_AW-1:0];
      end
      if (pop) begin
        head_r <= head_r + Q_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

/* hdl/base64_stream_encoder.sv */
// ---------------------------------------------------------------------------
// base64_stream_encoder
// Byte stream to base64-style characters, one character word per cycle while not stalled.
// ---------------------------------------------------------------------------
//
//   Channel  Ports                                   Moves
//   in       in_valid, in_stall, in_data_byte,       one message byte
//            in_end_of_message
//   out      out_valid, out_stall, out_char,         one ASCII character
//            out_last_char
//
// A byte is encoded in the cycle it is accepted and its one or two characters
// enter a four-entry queue; the output gives one character per cycle from the
// queue head while out_stall is low. A byte is taken whenever two queue slots
// are free, so the byte rate is set by the one-character output port, and a
// full group of three bytes yields four characters. Reset clears the group
// phase, the carry bits and the queue pointers.
// Output stalls fill the queue and then stall the input.
module base64_stream_encoder
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char,
  output logic       out_last_char
);

  logic     in_accept;
  logic     out_accept;
  logic     room;
  enc_res_t res;
  q_entry_t head;

  // Handshakes.
  assign in_stall   = !room;
  assign in_accept  = in_valid && room;
  assign out_accept = out_valid && !out_stall;

  // Symbol generation from the group state.
  b64e_encoder u_encoder (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .data_byte      (in_data_byte),
    .end_of_message (in_end_of_message),
    .res            (res)
  );

  // Characters waiting for the output.
  b64e_char_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .wr        (res),
    .pop       (out_accept),
    .room      (room),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_char      = head.ch;
  assign out_last_char = head.last;

endmodule
